### rtl/core/qrs_pkg.sv
// Shared widths, result kind codes and sideband types for the quadratic root solver.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package qrs_pkg;

   localparam int COEF_WIDTH  = 16;
   localparam int FRAC_BITS   = 16;
   localparam int VALUE_WIDTH = 40;
   localparam int KIND_WIDTH  = 2;

   // products and discriminant
   localparam int PROD_WIDTH = 2 * COEF_WIDTH;
   localparam int DISC_WIDTH = 2 * COEF_WIDTH + 3;
   localparam int MAG_WIDTH  = 2 * COEF_WIDTH + 2;

   // square root: radicand is |d| scaled by 2^(2*FRAC_BITS)
   localparam int RAD_WIDTH  = MAG_WIDTH + 2 * FRAC_BITS;
   localparam int ROOT_WIDTH = RAD_WIDTH / 2;
   localparam int SREM_WIDTH = ROOT_WIDTH + 2;

   // numerators and divisor
   localparam int NB_WIDTH   = COEF_WIDTH + FRAC_BITS + 1;
   localparam int NUM_WIDTH  = ROOT_WIDTH + 2;
   localparam int DEN_WIDTH  = COEF_WIDTH + 1;
   localparam int DMAG_WIDTH = COEF_WIDTH + 1;
   localparam int DREM_WIDTH = DMAG_WIDTH + 1;

   localparam int LANES = 2;

   // result kinds
   localparam logic [KIND_WIDTH-1:0] KIND_TWO_REAL = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_DOUBLE   = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_COMPLEX  = 2'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_DEGEN    = 2'd3;

   // sideband that rides along the square root pipeline
   typedef struct packed {
      logic [KIND_WIDTH-1:0]        kind;
      logic signed [NB_WIDTH-1:0]   nb;
      logic signed [DEN_WIDTH-1:0]  den;
   } qrs_side_type;

endpackage
`default_nettype wire

### rtl/core/qrs_front.sv
// Front end: two register stages forming b*b, a*c, then the discriminant and kind.
// Depends on qrs_pkg.
`default_nettype none
module qrs_front (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    advance,
   input  wire logic                                    in_valid,
   input  wire logic signed [qrs_pkg::COEF_WIDTH-1:0]   coef_a,
   input  wire logic signed [qrs_pkg::COEF_WIDTH-1:0]   coef_b,
   input  wire logic signed [qrs_pkg::COEF_WIDTH-1:0]   coef_c,
   output logic                                         out_valid,
   output logic [qrs_pkg::MAG_WIDTH-1:0]                out_mag,
   output qrs_pkg::qrs_side_type                        out_side
);
   import qrs_pkg::*;

   logic                            v1_ff;
   logic signed [PROD_WIDTH-1:0]    bb_ff, ac_ff;
   logic signed [COEF_WIDTH-1:0]    a1_ff, b1_ff;
   logic                            v2_ff;
   logic [MAG_WIDTH-1:0]            mag_ff, mag_in;
   qrs_side_type                    side_ff, side_in;
   logic signed [DISC_WIDTH-1:0]    disc;

   // stage one: products
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
      end
      if (advance) begin
         bb_ff <= coef_b * coef_b;
         ac_ff <= coef_a * coef_c;
         a1_ff <= coef_a;
         b1_ff <= coef_b;
      end
   end

   // stage two: discriminant, magnitude, kind, -b scaled, 2a
   always_comb begin
      disc = DISC_WIDTH'(bb_ff) - (DISC_WIDTH'(ac_ff) <<< 2);
      mag_in = disc[DISC_WIDTH-1] ? MAG_WIDTH'(-disc) : MAG_WIDTH'(disc);
      if (a1_ff == '0) begin
         side_in.kind = KIND_DEGEN;
      end else if (disc[DISC_WIDTH-1]) begin
         side_in.kind = KIND_COMPLEX;
      end else if (disc == '0) begin
         side_in.kind = KIND_DOUBLE;
      end else begin
         side_in.kind = KIND_TWO_REAL;
      end
      side_in.nb  = -(NB_WIDTH'(b1_ff) <<< FRAC_BITS);
      side_in.den = DEN_WIDTH'(a1_ff) <<< 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (advance) begin
         v2_ff <= v1_ff;
      end
      if (advance) begin
         mag_ff  <= mag_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_mag   = mag_ff;
   assign out_side  = side_ff;

endmodule
`default_nettype wire

### rtl/core/qrs_sqrt.sv
// Pipelined restoring square root, one root bit per register stage.
// Depends on qrs_pkg; sideband travels with each item.
`default_nettype none
module qrs_sqrt (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            advance,
   input  wire logic                            in_valid,
   input  wire logic [qrs_pkg::MAG_WIDTH-1:0]   in_mag,
   input  wire qrs_pkg::qrs_side_type           in_side,
   output logic                                 out_valid,
   output logic [qrs_pkg::ROOT_WIDTH-1:0]       out_root,
   output qrs_pkg::qrs_side_type                out_side
);
   import qrs_pkg::*;

   logic                    val_ff  [ROOT_WIDTH+1];
   logic [RAD_WIDTH-1:0]    rad_ff  [ROOT_WIDTH+1];
   logic [SREM_WIDTH-1:0]   rem_ff  [ROOT_WIDTH+1];
   logic [ROOT_WIDTH-1:0]   root_ff [ROOT_WIDTH+1];
   qrs_side_type            side_ff [ROOT_WIDTH+1];

   // entry stage: scale the radicand
   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff[0] <= 1'b0;
      end else if (advance) begin
         val_ff[0] <= in_valid;
      end
      if (advance) begin
         rad_ff[0]  <= RAD_WIDTH'(in_mag) << (2 * FRAC_BITS);
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         side_ff[0] <= in_side;
      end
   end

   // one root bit per stage
   for (genvar k = 0; k < ROOT_WIDTH; k++) begin : g_step
      logic [SREM_WIDTH-1:0] rem_sh, trial;
      logic                  take;
      always_comb begin
         rem_sh = {rem_ff[k][SREM_WIDTH-3:0], rad_ff[k][RAD_WIDTH-1 -: 2]};
         trial  = {root_ff[k], 2'b01};
         take   = (rem_sh >= trial);
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[k+1] <= 1'b0;
         end else if (advance) begin
            val_ff[k+1] <= val_ff[k];
         end
         if (advance) begin
            rad_ff[k+1]  <= rad_ff[k] << 2;
            rem_ff[k+1]  <= take ? rem_sh - trial : rem_sh;
            root_ff[k+1] <= {root_ff[k][ROOT_WIDTH-2:0], take};
            side_ff[k+1] <= side_ff[k];
         end
      end
   end

   assign out_valid = val_ff[ROOT_WIDTH];
   assign out_root  = root_ff[ROOT_WIDTH];
   assign out_side  = side_ff[ROOT_WIDTH];

endmodule
`default_nettype wire

### rtl/core/qrs_div.sv
// Two-lane pipelined restoring divider with truncation toward zero, plus output stage.
// Depends on qrs_pkg; both lanes share the divisor 2a.
`default_nettype none
module qrs_div (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    advance,
   input  wire logic                                    in_valid,
   input  wire logic [qrs_pkg::KIND_WIDTH-1:0]          in_kind,
   input  wire logic signed [qrs_pkg::NUM_WIDTH-1:0]    in_num [qrs_pkg::LANES],
   input  wire logic signed [qrs_pkg::DEN_WIDTH-1:0]    in_den,
   output logic                                         out_valid,
   output logic [qrs_pkg::KIND_WIDTH-1:0]               out_kind,
   output logic signed [qrs_pkg::VALUE_WIDTH-1:0]       out_value [qrs_pkg::LANES]
);
   import qrs_pkg::*;

   logic                    val_ff  [NUM_WIDTH+1];
   logic [KIND_WIDTH-1:0]   kind_ff [NUM_WIDTH+1];
   logic [DMAG_WIDTH-1:0]   dmag_ff [NUM_WIDTH+1];
   logic [NUM_WIDTH-1:0]    q_ff    [NUM_WIDTH+1][LANES];
   logic [DREM_WIDTH-1:0]   rem_ff  [NUM_WIDTH+1][LANES];
   logic                    neg_ff  [NUM_WIDTH+1][LANES];

   logic                            ov_ff;
   logic [KIND_WIDTH-1:0]           okind_ff;
   logic signed [VALUE_WIDTH-1:0]   oval_ff [LANES];

   // entry stage: take magnitudes and result signs
   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff[0] <= 1'b0;
      end else if (advance) begin
         val_ff[0] <= in_valid;
      end
      if (advance) begin
         kind_ff[0] <= in_kind;
         dmag_ff[0] <= in_den[DEN_WIDTH-1] ? DMAG_WIDTH'(-in_den) : DMAG_WIDTH'(in_den);
         for (int l = 0; l < LANES; l++) begin
            q_ff[0][l]   <= in_num[l][NUM_WIDTH-1] ? NUM_WIDTH'(-in_num[l])
                                                   : NUM_WIDTH'(in_num[l]);
            rem_ff[0][l] <= '0;
            neg_ff[0][l] <= in_num[l][NUM_WIDTH-1] ^ in_den[DEN_WIDTH-1];
         end
      end
   end

   // one quotient bit per stage in each lane
   for (genvar k = 0; k < NUM_WIDTH; k++) begin : g_step
      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [DREM_WIDTH-1:0] rem_sh;
         logic                  take;
         always_comb begin
            rem_sh = {rem_ff[k][l][DREM_WIDTH-2:0], q_ff[k][l][NUM_WIDTH-1]};
            take   = (rem_sh >= DREM_WIDTH'(dmag_ff[k]));
         end
         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[k+1][l] <= take ? rem_sh - DREM_WIDTH'(dmag_ff[k]) : rem_sh;
               q_ff[k+1][l]   <= {q_ff[k][l][NUM_WIDTH-2:0], take};
               neg_ff[k+1][l] <= neg_ff[k][l];
            end
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[k+1] <= 1'b0;
         end else if (advance) begin
            val_ff[k+1] <= val_ff[k];
         end
         if (advance) begin
            kind_ff[k+1] <= kind_ff[k];
            dmag_ff[k+1] <= dmag_ff[k];
         end
      end
   end

   // output stage: restore sign, zero a degenerate item
   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (advance) begin
         ov_ff <= val_ff[NUM_WIDTH];
      end
      if (advance) begin
         okind_ff <= kind_ff[NUM_WIDTH];
         for (int l = 0; l < LANES; l++) begin
            if (kind_ff[NUM_WIDTH] == KIND_DEGEN) begin
               oval_ff[l] <= '0;
            end else if (neg_ff[NUM_WIDTH][l]) begin
               oval_ff[l] <= -VALUE_WIDTH'(q_ff[NUM_WIDTH][l]);
            end else begin
               oval_ff[l] <= VALUE_WIDTH'(q_ff[NUM_WIDTH][l]);
            end
         end
      end
   end

   assign out_valid = ov_ff;
   assign out_kind  = okind_ff;
   assign out_value = oval_ff;

endmodule
`default_nettype wire

### rtl/core/quadratic_root_solver.sv
// Quadratic root solver: takes a, b, c each beat and returns kind and two fixed-point
// values with FRAC_BITS fraction bits. One item enters per cycle unless the pipeline
// holds; the front end, then the bit-per-stage square root and divider pipelines, lie
// between input and output. The whole pipeline holds while a result waits on
// rsp_tready. Depends on qrs_pkg, qrs_front, qrs_sqrt, qrs_div.
`default_nettype none
module quadratic_root_solver (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [47:0]   req_tdata,   // coef_a [15:0], coef_b [31:16], coef_c [47:32]
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [79:0]        rsp_tdata,   // first_value [39:0], second_value [79:40]
   output logic [1:0]         rsp_tuser    // root_kind [1:0]
);
   import qrs_pkg::*;

   logic                            advance;
   logic                            f_valid, s_valid, d_valid;
   logic [MAG_WIDTH-1:0]            f_mag;
   qrs_side_type                    f_side, s_side;
   logic [ROOT_WIDTH-1:0]           s_root;
   logic signed [NUM_WIDTH-1:0]     num [LANES];
   logic signed [NUM_WIDTH-1:0]     nb_ext, s_ext;
   logic [KIND_WIDTH-1:0]           d_kind;
   logic signed [VALUE_WIDTH-1:0]   d_value [LANES];

   // hold every stage while a result waits
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   qrs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_tvalid),
      .coef_a    (req_tdata[15:0]),
      .coef_b    (req_tdata[31:16]),
      .coef_c    (req_tdata[47:32]),
      .out_valid (f_valid),
      .out_mag   (f_mag),
      .out_side  (f_side)
   );

   qrs_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (f_valid),
      .in_mag    (f_mag),
      .in_side   (f_side),
      .out_valid (s_valid),
      .out_root  (s_root),
      .out_side  (s_side)
   );

   // pick the numerators by root kind
   always_comb begin
      nb_ext = NUM_WIDTH'(s_side.nb);
      s_ext  = NUM_WIDTH'({1'b0, s_root});
      case (s_side.kind)
         KIND_TWO_REAL: begin
            num[0] = nb_ext + s_ext;
            num[1] = nb_ext - s_ext;
         end
         KIND_DOUBLE: begin
            num[0] = nb_ext;
            num[1] = nb_ext;
         end
         KIND_COMPLEX: begin
            num[0] = nb_ext;
            num[1] = s_ext;
         end
         default: begin
            num[0] = '0;
            num[1] = '0;
         end
      endcase
   end

   qrs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s_valid),
      .in_kind   (s_side.kind),
      .in_num    (num),
      .in_den    (s_side.den),
      .out_valid (d_valid),
      .out_kind  (d_kind),
      .out_value (d_value)
   );

   assign rsp_tvalid = d_valid;
   assign rsp_tuser  = d_kind;
   assign rsp_tdata  = {d_value[1], d_value[0]};

   // a degenerate item carries zero values
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_DEGEN) |-> (rsp_tdata == '0))
      else $error("degenerate result with nonzero values");

   // a double root repeats the same value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == KIND_DOUBLE) |-> (rsp_tdata[79:40] == rsp_tdata[39:0]))
      else $error("double root values differ");

   // an input beat is taken only while the pipeline moves
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input taken during stall");

endmodule
`default_nettype wire

### sim/tb_quadratic_root_solver.sv
// Self-checking bench for quadratic_root_solver: streams coefficient sets, predicts
// kind and fixed-point roots in-bench and compares each rsp beat. Depends on qrs_pkg.
`timescale 1ns / 100ps
`default_nettype none
module tb_quadratic_root_solver;
   import qrs_pkg::*;

   typedef struct packed {
      logic [KIND_WIDTH-1:0]  kind;
      logic [VALUE_WIDTH-1:0] first;
      logic [VALUE_WIDTH-1:0] second;
   } roots_type;

   localparam int CYCLE_LIMIT = 400000;
   localparam int LATENCY     = 73;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   roots_type   expected_roots[$];
   int          mismatches = 0;
   int          cycles = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;

   quadratic_root_solver uut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // floor(sqrt(mag * 2^(2*FRAC_BITS))), bit by bit
   function automatic logic [63:0] scaled_root(input logic [63:0] mag);
      logic [127:0] rad;
      logic [127:0] cand;
      logic [63:0]  r;
      rad = {64'd0, mag} << (2 * FRAC_BITS);
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         cand = {64'd0, r | (64'd1 << i)};
         if (cand * cand <= rad) r = r | (64'd1 << i);
      end
      return r;
   endfunction

   function automatic roots_type solve_roots(input logic [47:0] coefs);
      roots_type res;
      longint a, b, c, d, nb, den, s, v1, v2;
      a = longint'($signed(coefs[15:0]));
      b = longint'($signed(coefs[31:16]));
      c = longint'($signed(coefs[47:32]));
      if (a == 0) begin
         res.kind = KIND_DEGEN;
         res.first = '0;
         res.second = '0;
         return res;
      end
      d = b * b - 4 * (a * c);
      nb = -b * (64'sd1 <<< FRAC_BITS);
      den = 2 * a;
      if (d > 0) begin
         s = longint'(scaled_root(d));
         v1 = (nb + s) / den;
         v2 = (nb - s) / den;
         res.kind = KIND_TWO_REAL;
      end else if (d == 0) begin
         v1 = nb / den;
         v2 = v1;
         res.kind = KIND_DOUBLE;
      end else begin
         s = longint'(scaled_root(-d));
         v1 = nb / den;
         v2 = s / den;
         res.kind = KIND_COMPLEX;
      end
      res.first = v1[VALUE_WIDTH-1:0];
      res.second = v2[VALUE_WIDTH-1:0];
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("error: %s got %h expected %h", what, got, want);
      mismatches++;
   endtask

   // send one coefficient beat, with random idle cycles up front; valid stays high
   // after the beat so that back-to-back beats need no second drive in one step
   task automatic send_coefs(input logic [15:0] a, input logic [15:0] b,
                             input logic [15:0] c);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {c, b, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_roots.push_back(solve_roots({c, b, a}));
   endtask

   // drop valid and wait until every expected beat is back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_roots.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   // receiver stall pattern
   always @(posedge clock) begin
      rsp_tready <= reset ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
   end

   // check each accepted result beat against the oldest prediction
   always @(posedge clock) begin
      roots_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_roots.size() == 0) begin
            report_mismatch("unexpected beat", rsp_tdata[63:0], 64'd0);
         end else begin
            want = expected_roots.pop_front();
            if (rsp_tuser != want.kind)
               report_mismatch("root_kind", 64'(rsp_tuser), 64'(want.kind));
            if (rsp_tdata[39:0] != want.first)
               report_mismatch("first_value", 64'(rsp_tdata[39:0]), 64'(want.first));
            if (rsp_tdata[79:40] != want.second)
               report_mismatch("second_value", 64'(rsp_tdata[79:40]), 64'(want.second));
         end
      end
   end

   // guard against a hang
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("quadratic_root_solver: mismatch");
         $finish;
      end
   end

   // extremes, each root kind, degenerate leading coefficient
   task automatic test_directed();
      send_coefs(16'h0000, 16'h1234, 16'h5678);
      send_coefs(16'h0000, 16'h0000, 16'h0000);
      send_coefs(16'h0001, 16'hFFFD, 16'h0002);
      send_coefs(16'h0001, 16'h0002, 16'h0001);
      send_coefs(16'h0004, 16'h0004, 16'h0001);
      send_coefs(16'h0001, 16'h0000, 16'h0001);
      send_coefs(16'hFFFF, 16'h0001, 16'h0005);
      send_coefs(16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_coefs(16'h8000, 16'h8000, 16'h8000);
      send_coefs(16'h8000, 16'h7FFF, 16'h7FFF);
      send_coefs(16'h7FFF, 16'h8000, 16'h8000);
      send_coefs(16'h0001, 16'h8000, 16'h8000);
      send_coefs(16'h0001, 16'h8000, 16'h7FFF);
      send_coefs(16'h0001, 16'h0000, 16'h8000);
      send_coefs(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_coefs(16'h0003, 16'h0007, 16'hFFFE);
      send_coefs(16'hFFFE, 16'h0003, 16'h0009);
   endtask

   // random sets, mixing full range, small values, perfect squares and zero a
   task automatic test_random(input int count);
      logic [15:0] a, b, c;
      int r;
      for (int i = 0; i < count; i++) begin
         a = 16'($urandom);
         b = 16'($urandom);
         c = 16'($urandom);
         case ($urandom_range(4))
            0: begin
               a = 16'($urandom_range(8) - 4);
               b = 16'($urandom_range(40) - 20);
               c = 16'($urandom_range(40) - 20);
            end
            1: begin
               // double root: a*(x-r)^2
               r = int'($urandom_range(200)) - 100;
               a = 16'($urandom_range(6) - 3);
               b = 16'(-2 * int'($signed(a)) * r);
               c = 16'(int'($signed(a)) * r * r);
            end
            2: a = 16'h0000;
            default: ;
         endcase
         send_coefs(a, b, c);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 36;
      recv_idle_pct = 66;
      test_directed();
      test_random(280);
      drain_results();
      send_idle_pct = 66;
      recv_idle_pct = 36;
      test_random(280);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(290);
      drain_results();
      if (mismatches == 0) begin
         $display("quadratic_root_solver: match");
      end else begin
         $display("quadratic_root_solver: mismatch");
      end
      $finish;
   end
endmodule
`default_nettype wire

### quadratic_root_solver.f
rtl/core/qrs_pkg.sv
rtl/core/qrs_front.sv
rtl/core/qrs_sqrt.sv
rtl/core/qrs_div.sv
rtl/core/quadratic_root_solver.sv
sim/tb_quadratic_root_solver.sv
